// ===== hw/rtl/servo_angle_deadband_slew_limiter_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SERVO_ANGLE_DEADBAND_SLEW_LIMITER_DEFINES_SVH
`define SERVO_ANGLE_DEADBAND_SLEW_LIMITER_DEFINES_SVH

// Same-cycle implication.
`define SADSL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SADSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/sadsl_pkg.sv =====
`timescale 1ns / 1ps
package sadsl_pkg;

   localparam int NUM_JOINTS = 5;
   localparam int ANGLE_W    = 8;
   localparam int STEP_W     = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef logic [ANGLE_W-1:0]    angle_type;
   typedef logic [STEP_W-1:0]     step_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Register indexes.
   localparam csr_idx_type CSR_MAX_STEP = 2'd0;
   localparam csr_idx_type CSR_DEADBAND = 2'd1;
   localparam csr_idx_type CSR_MAX_JUMP = 2'd2;

   localparam step_type  MAX_STEP_RESET = 4'd1;
   localparam angle_type DEADBAND_RESET = 8'd10;
   localparam angle_type MAX_JUMP_RESET = 8'd150;
   localparam angle_type HELD_RESET     = 8'd90;

   localparam angle_type ARM_LOW         = 8'd5;
   localparam angle_type ARM_HIGH        = 8'd175;
   localparam angle_type GRIP_LOW        = 8'd50;
   localparam angle_type GRIP_HIGH       = 8'd160;
   localparam angle_type GRIP_MIN_TARGET = 8'd40;

   typedef struct packed {
      step_type  max_step;
      angle_type deadband;
      angle_type max_jump;
   } cfg_type;

endpackage

// ===== hw/rtl/sadsl_req_if.sv =====
`timescale 1ns / 1ps
interface sadsl_req_if import sadsl_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type target_0;
   angle_type target_1;
   angle_type target_2;
   angle_type target_3;
   angle_type target_4;

   modport source (output valid, target_0, target_1, target_2, target_3, target_4,
                   input ready);
   modport sink (input valid, target_0, target_1, target_2, target_3, target_4,
                 output ready);
endinterface

interface sadsl_rsp_if import sadsl_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type held_out_0;
   angle_type held_out_1;
   angle_type held_out_2;
   angle_type held_out_3;
   angle_type held_out_4;

   modport source (output valid, held_out_0, held_out_1, held_out_2, held_out_3,
                   held_out_4, input ready);
   modport sink (input valid, held_out_0, held_out_1, held_out_2, held_out_3,
                 held_out_4, output ready);
endinterface

// ===== hw/rtl/sadsl_joint.sv =====
`timescale 1ns / 1ps
module sadsl_joint import sadsl_pkg::*; (
   input  cfg_type   cfg,
   input  logic      grip,
   input  logic      first,
   input  angle_type target,
   input  angle_type held,
   output angle_type held_next
);

   logic signed [ANGLE_W+1:0] t_s;
   logic signed [ANGLE_W+1:0] h_s;
   logic signed [ANGLE_W+1:0] up;
   logic signed [ANGLE_W+1:0] down;
   logic signed [ANGLE_W+1:0] db_s;
   logic signed [ANGLE_W+1:0] jump_s;
   logic signed [ANGLE_W+1:0] step_s;
   logic signed [ANGLE_W+1:0] lo_s;
   logic signed [ANGLE_W+1:0] hi_s;
   logic signed [ANGLE_W+1:0] moved;
   logic signed [ANGLE_W+1:0] clamped;
   logic                      up_ok;
   logic                      down_ok;
   logic                      target_ok;

   always_comb begin
      t_s    = signed'({2'b00, target});
      h_s    = signed'({2'b00, held});
      up     = t_s - h_s;
      down   = h_s - t_s;
      db_s   = signed'({2'b00, cfg.deadband});
      jump_s = signed'({2'b00, cfg.max_jump});
      step_s = signed'({{(ANGLE_W + 2 - STEP_W){1'b0}}, cfg.max_step});
      lo_s   = signed'({2'b00, (grip ? GRIP_LOW : ARM_LOW)});
      hi_s   = signed'({2'b00, (grip ? GRIP_HIGH : ARM_HIGH)});

      // The grip joint ignores max_jump but only follows targets of 40 and up.
      target_ok = (target >= GRIP_MIN_TARGET);
      up_ok     = grip ? (up >= db_s && target_ok) : (up >= db_s && up <= jump_s);
      down_ok   = grip ? (down >= db_s && target_ok)
                       : (down >= db_s && down <= jump_s);

      if (up_ok) begin
         moved = h_s + step_s;
      end else if (down_ok) begin
         moved = h_s - step_s;
      end else begin
         moved = h_s;
      end

      if (moved < lo_s) begin
         clamped = lo_s;
      end else if (moved > hi_s) begin
         clamped = hi_s;
      end else begin
         clamped = moved;
      end

      // The first item after reset is copied without clamping.
      held_next = first ? target : clamped[ANGLE_W-1:0];
   end

endmodule

// ===== hw/rtl/servo_angle_deadband_slew_limiter.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the result side stalls; the held angles
// are read and rewritten in the same cycle that an item moves from the input
// register to the result register.
// Reset (synchronous, active high): registers back to 1/10/150, held angles to 90,
// pipeline empty, and the next item is copied straight into the held angles.
module servo_angle_deadband_slew_limiter import sadsl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   sadsl_req_if.sink    req_chan,
   sadsl_rsp_if.source  rsp_chan,
   input  logic         csr_write_en,
   input  csr_idx_type  csr_index,
   input  csr_data_type csr_wdata
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      s1_valid_ff;
   logic      s1_valid_in;
   angle_type s1_target_ff [NUM_JOINTS];
   logic      out_valid_ff;
   logic      out_valid_in;
   angle_type held_ff [NUM_JOINTS];
   angle_type held_in [NUM_JOINTS];
   logic      first_ff;
   logic      first_in;
   angle_type req_target [NUM_JOINTS];
   logic      advance;
   logic      accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_STEP: cfg_in.max_step = csr_wdata[STEP_W-1:0];
            CSR_DEADBAND: cfg_in.deadband = csr_wdata[ANGLE_W-1:0];
            CSR_MAX_JUMP: cfg_in.max_jump = csr_wdata[ANGLE_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_target[0] = req_chan.target_0;
   assign req_target[1] = req_chan.target_1;
   assign req_target[2] = req_chan.target_2;
   assign req_target[3] = req_chan.target_3;
   assign req_target[4] = req_chan.target_4;

   // An item leaves the input register whenever the result register is free
   // or is being emptied in this cycle.
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   assign first_in     = first_ff && !advance;

   for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
      sadsl_joint u_joint (
         .cfg       (cfg_ff),
         .grip      (j == NUM_JOINTS - 1),
         .first     (first_ff),
         .target    (s1_target_ff[j]),
         .held      (held_ff[j]),
         .held_next (held_in[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_step <= MAX_STEP_RESET;
         cfg_ff.deadband <= DEADBAND_RESET;
         cfg_ff.max_jump <= MAX_JUMP_RESET;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         first_ff        <= 1'b1;
         for (int k = 0; k < NUM_JOINTS; k++) begin
            held_ff[k] <= HELD_RESET;
         end
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         first_ff     <= first_in;
         if (advance) begin
            for (int k = 0; k < NUM_JOINTS; k++) begin
               held_ff[k] <= held_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < NUM_JOINTS; k++) begin
            s1_target_ff[k] <= req_target[k];
         end
      end
   end

   // The held angles themselves serve as the result register.
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.held_out_0 = held_ff[0];
   assign rsp_chan.held_out_1 = held_ff[1];
   assign rsp_chan.held_out_2 = held_ff[2];
   assign rsp_chan.held_out_3 = held_ff[3];
   assign rsp_chan.held_out_4 = held_ff[4];

endmodule

// ===== hw/rtl/sadsl_checker.sv =====
`timescale 1ns / 1ps
`include "servo_angle_deadband_slew_limiter_defines.svh"
module sadsl_checker import sadsl_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input angle_type held_out_0,
   input angle_type held_out_4
);

   // Reset empties the result side.
   `SADSL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // With no result waiting, an item can always be taken.
   `SADSL_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // A stalled result keeps its angles.
   `SADSL_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(held_out_0) && $stable(held_out_4))

   // While the result side stalls, the held angles cannot be rewritten, so a
   // second new item cannot be taken on top of a full input register.
   `SADSL_ASSERT_NEXT(a_stall_backpressure, clock, reset,
      rsp_valid && !rsp_ready && req_valid && req_ready,
      rsp_ready || !req_ready)

endmodule

bind servo_angle_deadband_slew_limiter sadsl_checker u_sadsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .held_out_0 (rsp_chan.held_out_0),
   .held_out_4 (rsp_chan.held_out_4)
);

// ===== sim/servo_angle_deadband_slew_limiter_test.sv =====
`timescale 1ns / 1ps
module servo_angle_deadband_slew_limiter_test;
   import sadsl_pkg::*;

   typedef logic [NUM_JOINTS-1:0][ANGLE_W-1:0] angle_set_t;

   localparam csr_idx_type CSR_UNUSED = 2'd3;

   logic         clock;
   logic         reset;
   logic         csr_write_en;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   sadsl_req_if req_if();
   sadsl_rsp_if rsp_if();

   servo_angle_deadband_slew_limiter u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Our own copy of the limiter state and its registers.
   angle_set_t held_model   = {NUM_JOINTS{HELD_RESET}};
   bit         copy_pending = 1'b1;
   step_type   step_cfg     = MAX_STEP_RESET;
   angle_type  deadband_cfg = DEADBAND_RESET;
   angle_type  jump_cfg     = MAX_JUMP_RESET;

   angle_set_t held_expected[$];

   int items_sent      = 0;
   int results_checked = 0;
   int reg_writes      = 0;
   int mismatch_count  = 0;
   int error_count     = 0;

   bit req_steady   = 1'b0;
   bit rsp_steady   = 1'b0;
   int stall_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still outstanding", held_expected.size());
      $display("Some tests failed");
      $finish;
   end

   // Applies one accepted set of targets to the model and returns the new held angles.
   function automatic angle_set_t advance_held(input angle_set_t tgt);
      int t, h, up, down, stp, db, jmp, lo, hi, grip_min;
      stp      = int'(step_cfg);
      db       = int'(deadband_cfg);
      jmp      = int'(jump_cfg);
      grip_min = int'(GRIP_MIN_TARGET);
      if (copy_pending) begin
         held_model   = tgt;
         copy_pending = 1'b0;
      end else begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            t    = int'(tgt[j]);
            h    = int'(held_model[j]);
            up   = t - h;
            down = h - t;
            if (j < NUM_JOINTS - 1) begin
               lo = int'(ARM_LOW);
               hi = int'(ARM_HIGH);
               if (up >= db && up <= jmp)
                  h += stp;
               else if (down >= db && down <= jmp)
                  h -= stp;
            end else begin
               lo = int'(GRIP_LOW);
               hi = int'(GRIP_HIGH);
               if (up >= db && t >= grip_min)
                  h += stp;
               else if (down >= db && t >= grip_min)
                  h -= stp;
            end
            if (h < lo)
               h = lo;
            else if (h > hi)
               h = hi;
            held_model[j] = angle_type'(h);
         end
      end
      return held_model;
   endfunction

   function automatic angle_set_t pack5(input int a, input int b, input int c, input int d,
                                        input int e);
      angle_set_t s;
      s[0] = a[7:0];
      s[1] = b[7:0];
      s[2] = c[7:0];
      s[3] = d[7:0];
      s[4] = e[7:0];
      return s;
   endfunction

   // Targets at given offsets from the current held angles, kept inside 0..255.
   function automatic angle_set_t near_held(input int o0, input int o1, input int o2,
                                            input int o3, input int o4);
      int         offs[NUM_JOINTS];
      int         v;
      angle_set_t s;
      offs = '{o0, o1, o2, o3, o4};
      for (int j = 0; j < NUM_JOINTS; j++) begin
         v = int'(held_model[j]) + offs[j];
         if (v < 0)
            v = 0;
         else if (v > 255)
            v = 255;
         s[j] = angle_type'(v);
      end
      return s;
   endfunction

   // Most targets sit at offsets from the held angle, many on the deadband and jump edges, so that
   // every branch is reached; the rest are uniform over the whole field, some grip ones near 40.
   function automatic angle_set_t pick_targets();
      angle_set_t s;
      int         v, off, h;
      for (int j = 0; j < NUM_JOINTS; j++) begin
         h = int'(held_model[j]);
         if ($urandom_range(99) < 35) begin
            v = $urandom_range(255);
         end else begin
            case ($urandom_range(5))
               0: off = int'(deadband_cfg);
               1: off = int'(deadband_cfg) - 1;
               2: off = int'(jump_cfg);
               3: off = int'(jump_cfg) + 1;
               4: off = $urandom_range(20);
               default: off = $urandom_range(180);
            endcase
            v = ($urandom_range(1) == 1) ? h + off : h - off;
            if (v < 0)
               v = 0;
            else if (v > 255)
               v = 255;
         end
         if (j == NUM_JOINTS - 1 && $urandom_range(99) < 15)
            v = $urandom_range(44, 36);
         s[j] = angle_type'(v);
      end
      return s;
   endfunction

   task automatic send_targets(input angle_set_t tgt);
      while (!req_steady && $urandom_range(99) < 26) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.target_0 <= tgt[0];
      req_if.target_1 <= tgt[1];
      req_if.target_2 <= tgt[2];
      req_if.target_3 <= tgt[3];
      req_if.target_4 <= tgt[4];
      do @(posedge clock); while (req_if.ready !== 1'b1);
      held_expected.push_back(advance_held(tgt));
      items_sent++;
   endtask

   // Drops valid and waits until every expected result is back or a timeout runs out.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (held_expected.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input csr_data_type data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         CSR_MAX_STEP: step_cfg     = data[STEP_W-1:0];
         CSR_DEADBAND: deadband_cfg = data;
         CSR_MAX_JUMP: jump_cfg     = data;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic load_limits(input csr_data_type stp, input csr_data_type db,
                              input csr_data_type jmp);
      wait_drained();
      write_reg(CSR_MAX_STEP, stp);
      write_reg(CSR_DEADBAND, db);
      write_reg(CSR_MAX_JUMP, jmp);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_first_item_copy();
      // Out-of-range targets must be copied as they are on the first item.
      send_targets(pack5(255, 0, 181, 200, 30));
   endtask

   task automatic test_clamp_limits();
      send_targets(pack5(255, 0, 181, 200, 30));
      send_targets(pack5(180, 0, 180, 0, 180));
      send_targets(pack5(0, 180, 90, 20, 0));
   endtask

   task automatic test_zero_deadband();
      // With no deadband a zero gap qualifies both ways and the upward move wins.
      load_limits(15, 0, 180);
      send_targets(near_held(0, 0, 0, 0, 0));
      send_targets(near_held(0, 0, 0, 0, 0));
      send_targets(pack5(0, 255, 0, 255, 40));
      send_targets(pack5(255, 255, 255, 255, 255));
   endtask

   task automatic test_zero_step();
      load_limits(0, 0, 180);
      send_targets(near_held(0, 50, -50, 0, 0));
      send_targets(pack5(0, 180, 0, 180, 0));
   endtask

   task automatic test_grip_threshold();
      load_limits(4, 3, 180);
      send_targets(pack5(90, 90, 90, 90, 39));
      send_targets(pack5(90, 90, 90, 90, 40));
      send_targets(near_held(0, 0, 0, 0, -3));
      send_targets(near_held(0, 0, 0, 0, 2));
   endtask

   task automatic test_jump_window();
      load_limits(2, 10, 20);
      send_targets(near_held(20, 21, -20, -21, 10));
      send_targets(near_held(10, 9, -10, -9, -10));
   endtask

   task automatic test_register_masking();
      // The unused index must change nothing and max_step keeps only its low bits.
      wait_drained();
      write_reg(CSR_UNUSED, 8'h00);
      write_reg(CSR_MAX_STEP, 8'hF5);
      write_reg(CSR_DEADBAND, 8'hFF);
      write_reg(CSR_MAX_JUMP, 8'hFF);
      csr_write_en <= 1'b0;
      @(posedge clock);
      send_targets(near_held(12, -12, 40, -40, 12));
      send_targets(pack5(0, 255, 128, 127, 255));
   endtask

   task automatic test_output_backpressure();
      load_limits(3, 5, 120);
      req_steady   = 1'b1;
      stall_cycles = 120;
      repeat (40) send_targets(pick_targets());
      req_steady = 1'b0;
      wait_drained();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: load_limits(15, 0, 180);
            1: load_limits(0, 180, 0);
            2: load_limits(csr_data_type'(MAX_STEP_RESET), DEADBAND_RESET, MAX_JUMP_RESET);
            default: load_limits(csr_data_type'($urandom_range(255)),
                                 csr_data_type'($urandom_range(180)),
                                 csr_data_type'($urandom_range(180)));
         endcase
         // One whole phase runs with both sides at full rate.
         req_steady = (phase == 3);
         rsp_steady = (phase == 3);
         repeat (250) send_targets(pick_targets());
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   initial begin : rsp_driver
      int hold;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_cycles > 0) begin
            hold = stall_cycles;
            rsp_if.ready <= 1'b0;
            repeat (hold - 1) @(posedge clock);
            stall_cycles = 0;
         end else if (rsp_steady) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= 26);
         end
      end
   end

   always @(posedge clock) begin : held_checker
      angle_set_t got, want;
      if (reset !== 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got[0] = rsp_if.held_out_0;
         got[1] = rsp_if.held_out_1;
         got[2] = rsp_if.held_out_2;
         got[3] = rsp_if.held_out_3;
         got[4] = rsp_if.held_out_4;
         if (held_expected.size() == 0) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result at %0t: %p", $realtime, got);
         end else begin
            want = held_expected.pop_front();
            results_checked++;
            for (int j = 0; j < NUM_JOINTS; j++) begin
               if (got[j] !== want[j]) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("held_out_%0d mismatch at %0t: expected %0d, got %0d",
                              j, $realtime, want[j], got[j]);
               end
            end
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.target_0 <= '0;
      req_if.target_1 <= '0;
      req_if.target_2 <= '0;
      req_if.target_3 <= '0;
      req_if.target_4 <= '0;
      csr_write_en    <= 1'b0;
      csr_index       <= CSR_MAX_STEP;
      csr_wdata       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_item_copy();
      test_clamp_limits();
      test_zero_deadband();
      test_zero_step();
      test_grip_threshold();
      test_jump_window();
      test_register_masking();
      test_output_backpressure();
      test_random_phases();

      wait_drained();
      repeat (8) @(posedge clock);
      if (held_expected.size() != 0) begin
         $display("%0d expected results never arrived", held_expected.size());
         error_count += held_expected.size();
      end

      $display("Sent %0d target sets and checked %0d held-angle results after %0d writes.",
               items_sent, results_checked, reg_writes);
      $display("Covered first-item copy, clamps, deadband and jump edges, grip threshold,");
      $display("register masking and a long output stall; %0d errors.", error_count);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
